[hw/rtl/lbef_pkg.sv]
// Shared types and constants for the letterbox empty fraction block.
// Controller commands, datapath status and the stream word layout.
// No dependencies.
`default_nettype none

package lbef_pkg;

  // fixed field widths of the stream words
  localparam int unsigned IN_W    = 12;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned S_TDATA_W = 4 * IN_W;
  localparam int unsigned M_TDATA_W = 2 * OUT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_Q,
    ST_DIFF,
    ST_CHECK,
    ST_STRIP,
    ST_GCD,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic mul_p;
    logic mul_q;
    logic diff;
    logic strip_step;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic equal;      // cross products match, result is 0/1
    logic strip_done; // at least one operand is odd
    logic gcd_done;   // operands met
    logic div_last;   // final quotient bit this cycle
    logic out_free;   // output register can take a word
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/lbef_div.sv]
// Restoring divider lane, one quotient bit per step.
// Depends on nothing; instanced by lbef_dp.
`default_nettype none

module lbef_div #(
  parameter int unsigned W = 24
) (
  input  wire logic         clk_i,
  input  wire logic         start_i,
  input  wire logic         step_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic      [W-1:0] quotient_o
);

  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] dvs_q, dvs_d;
  logic [W:0]   trial;
  logic         fits;

  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (step_i) begin
      rem_d = fits ? W'(trial - {1'b0, dvs_q}) : W'(trial);
      quo_d = {quo_q[W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[hw/rtl/lbef_dp.sv]
// Datapath: side registers, shared multiplier, difference, binary GCD,
// two divider lanes and the output register. Uses lbef_pkg and lbef_div.
`default_nettype none

module lbef_dp #(
  parameter int unsigned SIDE_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lbef_pkg::cmd_t                  cmd_i,
  output lbef_pkg::sts_t                       sts_o,
  input  wire logic [lbef_pkg::S_TDATA_W-1:0]  in_data_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic      [lbef_pkg::M_TDATA_W-1:0]  out_data_o
);

  localparam int unsigned SW = SIDE_BITS;
  localparam int unsigned PW = 2 * SIDE_BITS;
  localparam int unsigned KW = $clog2(PW);
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned IW = lbef_pkg::IN_W;
  localparam int unsigned OW = lbef_pkg::OUT_W;

  logic [SW-1:0] sw_q, sh_q, fw_q, fh_q;
  logic [SW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] p_q, q_q;
  logic [PW-1:0] num_q, den_q;
  logic [PW-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          equal_q;
  logic [PW-1:0] gcd_val;
  logic [PW-1:0] quo_num, quo_den;
  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] out_num_q, out_den_q;

  // side registers, each field taken in its low SIDE_BITS bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sw_q <= SW'(in_data_i[IW-1:0]);
      sh_q <= SW'(in_data_i[2*IW-1:IW]);
      fw_q <= SW'(in_data_i[3*IW-1:2*IW]);
      fh_q <= SW'(in_data_i[4*IW-1:3*IW]);
    end
  end

  // one multiplier, used for both cross products
  always_comb begin
    mul_a = cmd_i.mul_q ? sh_q : sw_q;
    mul_b = cmd_i.mul_q ? fw_q : fh_q;
    prod  = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_p) p_q <= prod;
    if (cmd_i.mul_q) q_q <= prod;
    if (cmd_i.diff) begin
      equal_q <= p_q == q_q;
      if (p_q > q_q) begin
        den_q <= p_q;
        num_q <= p_q - q_q;
      end else begin
        den_q <= q_q;
        num_q <= q_q - p_q;
      end
    end
  end

  // binary GCD: strip common twos, then shift / subtract until equal
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.strip_step) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + KW'(1);
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      a_q <= (p_q > q_q) ? p_q : q_q;
      b_q <= (p_q > q_q) ? (p_q - q_q) : (q_q - p_q);
      k_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
      k_q <= k_d;
    end
  end

  assign gcd_val = a_q << k_q;

  // bit counter for the divider lanes
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.div_start) begin
      cnt_d = CW'(PW);
    end else if (cmd_i.div_step) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  lbef_div #(.W(PW)) u_div_num (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (num_q),
    .divisor_i  (gcd_val),
    .quotient_o (quo_num)
  );

  lbef_div #(.W(PW)) u_div_den (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (den_q),
    .divisor_i  (gcd_val),
    .quotient_o (quo_den)
  );

  // output register
  always_comb begin
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_num_q <= equal_q ? '0 : OW'(quo_num);
      out_den_q <= equal_q ? OW'(1) : OW'(quo_den);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_den_q, out_num_q};

  always_comb begin
    sts_o.equal      = equal_q;
    sts_o.strip_done = a_q[0] | b_q[0];
    sts_o.gcd_done   = a_q == b_q;
    sts_o.div_last   = cnt_q == CW'(1);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

[hw/rtl/lbef_ctrl.sv]
// Controller state machine: sequences multiply, GCD and divide steps.
// Uses lbef_pkg for the state enum and command/status structs.
`default_nettype none

module lbef_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lbef_pkg::sts_t sts_i,
  output lbef_pkg::cmd_t      cmd_o
);

  lbef_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbef_pkg::ST_IDLE:     if (in_valid_i) state_d = lbef_pkg::ST_MUL_P;
      lbef_pkg::ST_MUL_P:    state_d = lbef_pkg::ST_MUL_Q;
      lbef_pkg::ST_MUL_Q:    state_d = lbef_pkg::ST_DIFF;
      lbef_pkg::ST_DIFF:     state_d = lbef_pkg::ST_CHECK;
      lbef_pkg::ST_CHECK: begin
        state_d = sts_i.equal ? lbef_pkg::ST_FINISH : lbef_pkg::ST_STRIP;
      end
      lbef_pkg::ST_STRIP:    if (sts_i.strip_done) state_d = lbef_pkg::ST_GCD;
      lbef_pkg::ST_GCD:      if (sts_i.gcd_done) state_d = lbef_pkg::ST_DIV_INIT;
      lbef_pkg::ST_DIV_INIT: state_d = lbef_pkg::ST_DIV;
      lbef_pkg::ST_DIV:      if (sts_i.div_last) state_d = lbef_pkg::ST_FINISH;
      lbef_pkg::ST_FINISH:   if (sts_i.out_free) state_d = lbef_pkg::ST_IDLE;
      default:               state_d = lbef_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbef_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lbef_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      lbef_pkg::ST_MUL_P:    cmd_o.mul_p = 1'b1;
      lbef_pkg::ST_MUL_Q:    cmd_o.mul_q = 1'b1;
      lbef_pkg::ST_DIFF:     cmd_o.diff  = 1'b1;
      lbef_pkg::ST_CHECK:    ;
      lbef_pkg::ST_STRIP:    cmd_o.strip_step = !sts_i.strip_done;
      lbef_pkg::ST_GCD:      cmd_o.gcd_step   = !sts_i.gcd_done;
      lbef_pkg::ST_DIV_INIT: cmd_o.div_start  = 1'b1;
      lbef_pkg::ST_DIV:      cmd_o.div_step   = 1'b1;
      lbef_pkg::ST_FINISH:   cmd_o.load_out   = sts_i.out_free;
      default:               ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/letterbox_empty_fraction_top.sv]
// Letterbox empty fraction: one item in, one reduced fraction out.
// When the ratios match, the result goes straight to the output register; otherwise the
// binary GCD steps (strip and shift/subtract) and the divider steps run first. The
// finished result waits until the output register is free. One item at a time: the next
// word is taken only after the result is loaded into the output register and the FSM is idle.
// rst_ni clears the controller, the divider bit counter and the output valid flag.
`default_nettype none

module letterbox_empty_fraction_top #(
  parameter int unsigned SIDE_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // screen_width, screen_height, frame_width, frame_height (12 bits each)
  input  wire logic [lbef_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // empty_numerator, empty_denominator (24 bits each)
  output logic      [lbef_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  lbef_pkg::cmd_t cmd;
  lbef_pkg::sts_t sts;

  lbef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbef_dp #(.SIDE_BITS(SIDE_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for letterbox_empty_fraction_top: directed and random ratio pairs on the input stream.
// Each fraction on the output stream is checked against a local GCD predictor.
// Depends on lbef_pkg and the top-level RTL.

module tb_top;

  // packed so that screen_width lands in the low bits of tdata
  typedef struct packed {
    logic [lbef_pkg::IN_W-1:0] frame_height;
    logic [lbef_pkg::IN_W-1:0] frame_width;
    logic [lbef_pkg::IN_W-1:0] screen_height;
    logic [lbef_pkg::IN_W-1:0] screen_width;
  } ratio_pair_t;

  typedef struct packed {
    logic [lbef_pkg::OUT_W-1:0] denominator;
    logic [lbef_pkg::OUT_W-1:0] numerator;
  } fraction_t;

  logic                           clk_i   = 1'b0;
  logic                           rst_ni  = 1'b0;
  logic                           s_valid = 1'b0;
  logic [lbef_pkg::S_TDATA_W-1:0] s_data  = '0;
  logic                           m_ready = 1'b0;
  wire                            s_ready;
  wire                            m_valid;
  wire  [lbef_pkg::M_TDATA_W-1:0] m_data;

  fraction_t pending_fractions[$];
  int        mismatches = 0;
  bit        no_idle    = 1'b0;

  letterbox_empty_fraction_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // |P - Q| / max(P, Q) reduced, with P = sw*fh and Q = sh*fw
  function automatic fraction_t empty_fraction(ratio_pair_t r);
    longint unsigned p, q, diff, hi, a, b, t;
    fraction_t f;
    p = longint'(r.screen_width) * longint'(r.frame_height);
    q = longint'(r.screen_height) * longint'(r.frame_width);
    if (p > q) begin
      hi = p;
      diff = p - q;
    end else begin
      hi = q;
      diff = q - p;
    end
    if (diff == 0) begin
      f.numerator = '0;
      f.denominator = lbef_pkg::OUT_W'(1);
    end else begin
      a = hi;
      b = diff;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      f.numerator = lbef_pkg::OUT_W'(diff / a);
      f.denominator = lbef_pkg::OUT_W'(hi / a);
    end
    return f;
  endfunction

  task automatic send_ratios(int sw, int sh, int fw, int fh);
    ratio_pair_t r;
    r.screen_width = lbef_pkg::IN_W'(sw);
    r.screen_height = lbef_pkg::IN_W'(sh);
    r.frame_width = lbef_pkg::IN_W'(fw);
    r.frame_height = lbef_pkg::IN_W'(fh);
    if (!no_idle) begin
      while ($urandom_range(99) < 36) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data <= r;
    do @(posedge clk_i); while (!s_ready);
    pending_fractions.push_back(empty_fraction(r));
  endtask

  task automatic stop_sending();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random back-pressure, compare against oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t got, want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got = m_data;
        if (pending_fractions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: num=%0d den=%0d", got.numerator, got.denominator);
        end else begin
          want = pending_fractions.pop_front();
          if (got.numerator !== want.numerator || got.denominator !== want.denominator) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d, got %0d/%0d", want.numerator,
                       want.denominator, got.numerator, got.denominator);
          end
        end
      end
      m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  task automatic test_directed();
    send_ratios(4095, 4095, 4095, 4095);  // matching, all max
    send_ratios(1, 1, 1, 1);              // matching, all min
    send_ratios(4095, 1, 1, 4095);        // P huge, Q = 1
    send_ratios(1, 4095, 4095, 1);        // Q huge, P = 1
    send_ratios(16, 9, 4, 3);             // widescreen screen, 4:3 film
    send_ratios(4, 3, 16, 9);
    send_ratios(2, 3, 4, 6);              // same ratio, scaled
    send_ratios(4093, 4091, 4079, 4073);  // large primes
    send_ratios(4095, 4094, 4094, 4095);
    send_ratios(12'hAAA, 12'h555, 12'h555, 12'hAAA);
    send_ratios(12'h555, 12'hAAA, 12'hAAA, 12'h555);
    send_ratios(1, 2, 1, 2);
    send_ratios(2048, 1, 1, 2048);        // powers of two only
    send_ratios(0, 7, 5, 9);              // one cross product zero -> 1/1
    send_ratios(7, 9, 0, 5);
    send_ratios(0, 7, 0, 9);              // both zero -> 0/1
    send_ratios(0, 0, 0, 0);
    send_ratios(4095, 0, 4095, 0);
    send_ratios(3, 5, 5, 3);
    send_ratios(1000, 999, 999, 1000);
  endtask

  task automatic test_random_ratios(int n);
    repeat (n) begin
      if ($urandom_range(99) < 3)
        send_ratios($urandom_range(4095, 0), $urandom_range(4095, 0),
                    $urandom_range(4095, 0), $urandom_range(4095, 0));
      else
        send_ratios($urandom_range(4095, 1), $urandom_range(4095, 1),
                    $urandom_range(4095, 1), $urandom_range(4095, 1));
    end
  endtask

  // sides built from a shared base ratio so both products often match
  task automatic test_matching_ratios(int n);
    int a, b, k1, k2;
    repeat (n) begin
      a = $urandom_range(63, 1);
      b = $urandom_range(63, 1);
      k1 = $urandom_range(4095 / (a > b ? a : b), 1);
      k2 = $urandom_range(4095 / (a > b ? a : b), 1);
      if ($urandom_range(3) == 0)
        send_ratios(a * k1, b * k1, b * k2, a * k2);
      else
        send_ratios(a * k1, b * k1, a * k2, b * k2);
    end
  endtask

  task automatic test_small_sides(int n);
    repeat (n)
      send_ratios($urandom_range(16, 1), $urandom_range(16, 1),
                  $urandom_range(16, 1), $urandom_range(16, 1));
  endtask

  task automatic test_back_to_back(int n);
    no_idle = 1'b1;
    test_random_ratios(n);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_ratios(700);
    test_matching_ratios(250);
    test_small_sides(300);
    test_back_to_back(250);
    test_random_ratios(100);
    stop_sending();
    while (pending_fractions.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && pending_fractions.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // watchdog: ends the run with an error report if the test hangs
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lbef_pkg.sv
hw/rtl/lbef_div.sv
hw/rtl/lbef_dp.sv
hw/rtl/lbef_ctrl.sv
hw/rtl/letterbox_empty_fraction_top.sv
sim/tb_top.sv
